### hdl/alm_pkg.sv
// ---------------------------------------------------------------------------
// Audio level meter package
// Shared constants, control word and status types for the bar meter.
// ---------------------------------------------------------------------------
package alm_pkg;

  localparam int DEFAULT_LEVELS    = 23;
  localparam int DEFAULT_MAX_BLOCK = 1024;

  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = 16;
  localparam int THR_W           = 16;
  localparam int LEVEL_W         = 5;
  localparam int COLOR_W         = 8;
  localparam int POS_W           = 7;
  localparam int THRESHOLD_RESET = 200;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_TAKE     = 3'd0;
  localparam step_t STEP_DIV_LOAD = 3'd1;
  localparam step_t STEP_DIV_RUN  = 3'd2;
  localparam step_t STEP_PREP     = 3'd3;
  localparam step_t STEP_EMIT     = 3'd4;
  localparam step_t STEP_WRAP     = 3'd5;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NOT_LAST,
    JMP_DIV_MORE,
    JMP_MORE_LEVELS
  } jump_cond_t;

  typedef struct packed {
    logic       take_in;
    logic       div_load;
    logic       div_step;
    logic       prep;
    logic       emit;
    jump_cond_t cond;
    step_t      target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic div_more;
    logic more_levels;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

### hdl/alm_divider.sv
// ---------------------------------------------------------------------------
// Audio level meter divider
// Restoring divider, one quotient bit per step, DW steps per division.
// ---------------------------------------------------------------------------
module alm_divider #(
  parameter int DW = 26,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          step,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          more
);
  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [VW-1:0] rem;
  logic [VW-1:0] denom;
  logic [CW-1:0] bits_left;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem, quotient[DW-1]};
  assign fits    = shifted >= {1'b0, denom};
  assign more    = bits_left != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
    end else if (load) begin
      quotient  <= dividend;
      // hold the divisor, the sample count is cleared once the division starts
      denom     <= divisor;
      rem       <= '0;
      bits_left <= CW'(DW - 1);
    end else if (step) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem       <= fits ? VW'(shifted - {1'b0, denom}) : shifted[VW-1:0];
      quotient  <= {quotient[DW-2:0], fits};
      bits_left <= bits_left - 1'b1;
    end
  end

endmodule

### hdl/alm_sequencer.sv
// ---------------------------------------------------------------------------
// Audio level meter sequencer
// Step counter over a six-word control program with conditional jumps.
// ---------------------------------------------------------------------------
module alm_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  alm_pkg::dp_status_t st,
  output alm_pkg::ctrl_word_t cw
);
  import alm_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  hold;
  logic  jump;

  // Control program
  always_comb begin
    cw = '{take_in: 1'b0, div_load: 1'b0, div_step: 1'b0, prep: 1'b0, emit: 1'b0,
           cond: JMP_ALWAYS, target: STEP_TAKE};
    case (pc)
      STEP_TAKE: begin
        cw.take_in = 1'b1;
        cw.cond    = JMP_NOT_LAST;
        cw.target  = STEP_TAKE;
      end
      STEP_DIV_LOAD: begin
        cw.div_load = 1'b1;
        cw.cond     = JMP_NEVER;
      end
      STEP_DIV_RUN: begin
        cw.div_step = 1'b1;
        cw.cond     = JMP_DIV_MORE;
        cw.target   = STEP_DIV_RUN;
      end
      STEP_PREP: begin
        cw.prep = 1'b1;
        cw.cond = JMP_NEVER;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = JMP_MORE_LEVELS;
        cw.target = STEP_EMIT;
      end
      STEP_WRAP: begin
        cw.cond   = JMP_ALWAYS;
        cw.target = STEP_TAKE;
      end
      default: begin
        cw.cond   = JMP_ALWAYS;
        cw.target = STEP_TAKE;
      end
    endcase
  end

  always_comb begin
    case (cw.cond)
      JMP_NEVER:       jump = 1'b0;
      JMP_ALWAYS:      jump = 1'b1;
      JMP_NOT_LAST:    jump = !st.in_last;
      JMP_DIV_MORE:    jump = st.div_more;
      JMP_MORE_LEVELS: jump = st.more_levels;
      default:         jump = 1'b0;
    endcase
  end

  // hold the step while waiting for a sample or for room at the output
  assign hold    = (cw.take_in && !st.in_fire) || (cw.emit && !st.out_free);
  assign pc_next = hold ? pc : (jump ? cw.target : step_t'(pc + 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hdl/alm_datapath.sv
// ---------------------------------------------------------------------------
// Audio level meter datapath
// Magnitude accumulator, mean divider, level compare and output register.
// ---------------------------------------------------------------------------
module alm_datapath #(
  parameter int LEVELS    = alm_pkg::DEFAULT_LEVELS,
  parameter int MAX_BLOCK = alm_pkg::DEFAULT_MAX_BLOCK
) (
  input  logic                                clk,
  input  logic                                rst,
  input  alm_pkg::ctrl_word_t                 cw,
  output alm_pkg::dp_status_t                 st,
  input  logic                                cfg_we,
  input  logic [alm_pkg::THR_W-1:0]           cfg_wdata,
  input  logic                                sample_valid,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                last_sample,
  input  logic                                result_stall,
  output logic                                result_valid,
  output logic [alm_pkg::LEVEL_W-1:0]         level,
  output logic [alm_pkg::COLOR_W-1:0]         red,
  output logic [alm_pkg::COLOR_W-1:0]         green,
  output logic [alm_pkg::COLOR_W-1:0]         blue,
  output logic                                lit,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_first,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_second,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_third,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_fourth,
  output logic                                last_level
);
  import alm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = MAG_W - 1 + CNT_W;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int CMP_W = THR_W + $clog2(LEVELS + 1);

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic [THR_W-1:0] threshold;
  logic [MAG_W-1:0] magnitude;
  logic [SUM_W-1:0] quotient;
  logic             div_more;
  logic [CMP_W-1:0] mean_scaled;
  logic [CMP_W-1:0] level_thr;
  logic [LVL_W-1:0] j;
  logic             lit_now;
  logic             emit_load;
  color_t           color_tab [LEVELS];
  color_t           color_sel;

  // Per-level gradient, worked out at elaboration
  for (genvar k = 0; k < LEVELS; k++) begin : g_color
    localparam int J3  = 3 * k;
    localparam int RL  = (510 * k) / LEVELS;
    localparam int GM  = (J3 >= LEVELS) ? (170 * (J3 - LEVELS)) / LEVELS : 0;
    localparam int BT  = (J3 >= 2 * LEVELS) ? (255 * (J3 - 2 * LEVELS)) / LEVELS : 0;
    localparam int GT  = (BT >= 170) ? 0 : 170 - BT;
    localparam int RV  = (J3 < LEVELS) ? RL : ((J3 < 2 * LEVELS) ? 170 - GM : 1);
    localparam int GV  = (J3 < LEVELS) ? 0 : ((J3 < 2 * LEVELS) ? GM : GT);
    localparam int BV  = (J3 < LEVELS) ? 255 - RL : ((J3 < 2 * LEVELS) ? 0 : BT);
    assign color_tab[k] = '{red: COLOR_W'(RV), green: COLOR_W'(GV), blue: COLOR_W'(BV)};
  end

  assign magnitude = sample_value[SAMPLE_W-1] ? MAG_W'(~sample_value + 1'b1)
                                              : MAG_W'(sample_value);

  alm_divider #(
    .DW(SUM_W),
    .VW(CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .load     (cw.div_load),
    .step     (cw.div_step),
    .dividend (sum),
    .divisor  (count),
    .quotient (quotient),
    .more     (div_more)
  );

  assign st.in_fire     = cw.take_in && sample_valid;
  assign st.in_last     = last_sample;
  assign st.div_more    = div_more;
  assign st.more_levels = j != LVL_W'(LEVELS - 1);
  assign st.out_free    = !result_valid || !result_stall;

  assign emit_load = cw.emit && st.out_free;
  assign lit_now   = mean_scaled >= level_thr;
  assign color_sel = color_tab[j];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      count        <= '0;
      threshold    <= THR_W'(THRESHOLD_RESET);
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      // drop samples past a full block
      if (st.in_fire && count < CNT_W'(MAX_BLOCK)) begin
        sum   <= sum + SUM_W'(magnitude);
        count <= count + 1'b1;
      end
      if (cw.div_load) begin
        sum   <= '0;
        count <= '0;
      end
      if (cw.prep) begin
        mean_scaled <= CMP_W'(quotient[MAG_W-1:0]) * CMP_W'(LEVELS);
        level_thr   <= '0;
        j           <= '0;
      end
      if (emit_load) begin
        level            <= LEVEL_W'(j);
        red              <= lit_now ? color_sel.red   : '0;
        green            <= lit_now ? color_sel.green : '0;
        blue             <= lit_now ? color_sel.blue  : '0;
        lit              <= lit_now;
        strip_pos_first  <= POS_W'(j);
        strip_pos_second <= POS_W'(2 * LEVELS - 1 - int'(j));
        strip_pos_third  <= POS_W'(2 * LEVELS + int'(j));
        strip_pos_fourth <= POS_W'(4 * LEVELS - 1 - int'(j));
        last_level       <= j == LVL_W'(LEVELS - 1);
        j                <= j + 1'b1;
        level_thr        <= level_thr + CMP_W'(threshold);
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cw.div_load |-> count != '0)
    else $error("division started with a zero sample count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCK))
    else $error("sample count beyond block limit");

  a_emit_cleared: assert property (@(posedge clk) disable iff (rst)
    cw.emit |-> (sum == '0 && count == '0))
    else $error("accumulator not cleared while emitting levels");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (st.in_fire && last_sample) |=> !cw.take_in)
    else $error("sample taken right after a block end");

endmodule

### hdl/audio_level_bar_meter_top.sv
// ---------------------------------------------------------------------------
// Audio level bar meter
// Block-mean magnitude meter that emits one colored bar level per result.
// ---------------------------------------------------------------------------
// Samples are taken one per clock while the block accumulates. The transfer
// of a sample flagged last_sample starts the result run: load the divider,
// run the restoring divider (one quotient bit per cycle over a SUM_W-bit
// quotient, SUM_W = 15 + clog2(MAX_BLOCK+1), 26 with defaults), scale the
// mean, emit LEVELS level results (one per cycle unless the output stalls)
// and return to taking samples; sample_stall is high through the whole run.
// Samples beyond MAX_BLOCK in one block are dropped; a last sample still
// ends the block. The level threshold resets to 200 and is written through
// cfg_we.
module audio_level_bar_meter_top #(
  parameter int LEVELS    = alm_pkg::DEFAULT_LEVELS,
  parameter int MAX_BLOCK = alm_pkg::DEFAULT_MAX_BLOCK
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [alm_pkg::THR_W-1:0]           cfg_wdata,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                last_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [alm_pkg::LEVEL_W-1:0]         level,
  output logic [alm_pkg::COLOR_W-1:0]         red,
  output logic [alm_pkg::COLOR_W-1:0]         green,
  output logic [alm_pkg::COLOR_W-1:0]         blue,
  output logic                                lit,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_first,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_second,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_third,
  output logic [alm_pkg::POS_W-1:0]           strip_pos_fourth,
  output logic                                last_level
);
  import alm_pkg::*;

  ctrl_word_t cw;
  dp_status_t st;

  assign sample_stall = !cw.take_in;

  alm_sequencer u_sequencer (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cw  (cw)
  );

  alm_datapath #(
    .LEVELS    (LEVELS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cw               (cw),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .sample_valid     (sample_valid),
    .sample_value     (sample_value),
    .last_sample      (last_sample),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .level            (level),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .lit              (lit),
    .strip_pos_first  (strip_pos_first),
    .strip_pos_second (strip_pos_second),
    .strip_pos_third  (strip_pos_third),
    .strip_pos_fourth (strip_pos_fourth),
    .last_level       (last_level)
  );

endmodule
